>>> hdl/bsls_pkg.sv
// Shared types, result codes and the control-store program of the sort/search block.
package bsls_pkg;

    localparam int DATA_W = 16;
    localparam int POS_W  = 7;
    localparam int UPC_W  = 4;

    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [1:0] {
        KIND_SORTED = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_in_item;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] value_res;
        logic [POS_W-1:0]         position;
        logic                     last_res;
    } t_out_item;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // datapath actions, one per control word
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_SORT_INIT,
        ACT_RD_FIRST,
        ACT_TAKE_CUR,
        ACT_STEP,
        ACT_PASS_END,
        ACT_EMIT,
        ACT_SRCH,
        ACT_SRCH_END,
        ACT_NOTFOUND
    } t_act;

    // jump conditions; jump to target when true, else fall through
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_START,
        COND_IS_SEARCH,
        COND_NOT_LAST,
        COND_FEW,
        COND_MORE_STEP,
        COND_MORE_PASS,
        COND_MORE_SCAN,
        COND_EMPTY,
        COND_PEND
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
    } t_uword;

    localparam t_upc UPC_IDLE       = 4'd0;
    localparam t_upc UPC_DECODE     = 4'd1;
    localparam t_upc UPC_LOAD       = 4'd2;
    localparam t_upc UPC_SORT_INIT  = 4'd3;
    localparam t_upc UPC_PASS_START = 4'd4;
    localparam t_upc UPC_TAKE_CUR   = 4'd5;
    localparam t_upc UPC_STEP       = 4'd6;
    localparam t_upc UPC_PASS_END   = 4'd7;
    localparam t_upc UPC_EMIT_INIT  = 4'd8;
    localparam t_upc UPC_EMIT       = 4'd9;
    localparam t_upc UPC_DONE       = 4'd10;
    localparam t_upc UPC_SRCH_INIT  = 4'd11;
    localparam t_upc UPC_SRCH       = 4'd12;
    localparam t_upc UPC_SRCH_END   = 4'd13;
    localparam t_upc UPC_NOTFOUND   = 4'd14;

    function automatic t_uword uc_rom(input t_upc addr);
        t_uword w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, target: UPC_IDLE};
        unique case (addr)
            UPC_IDLE:       w = '{ACT_NONE,      COND_NOT_START, UPC_IDLE};
            UPC_DECODE:     w = '{ACT_NONE,      COND_IS_SEARCH, UPC_SRCH_INIT};
            UPC_LOAD:       w = '{ACT_LOAD,      COND_NOT_LAST,  UPC_IDLE};
            UPC_SORT_INIT:  w = '{ACT_SORT_INIT, COND_FEW,       UPC_EMIT_INIT};
            UPC_PASS_START: w = '{ACT_RD_FIRST,  COND_NEVER,     UPC_IDLE};
            UPC_TAKE_CUR:   w = '{ACT_TAKE_CUR,  COND_NEVER,     UPC_IDLE};
            UPC_STEP:       w = '{ACT_STEP,      COND_MORE_STEP, UPC_STEP};
            UPC_PASS_END:   w = '{ACT_PASS_END,  COND_MORE_PASS, UPC_PASS_START};
            UPC_EMIT_INIT:  w = '{ACT_RD_FIRST,  COND_NEVER,     UPC_IDLE};
            UPC_EMIT:       w = '{ACT_EMIT,      COND_MORE_SCAN, UPC_EMIT};
            UPC_DONE:       w = '{ACT_NONE,      COND_ALWAYS,    UPC_IDLE};
            UPC_SRCH_INIT:  w = '{ACT_RD_FIRST,  COND_EMPTY,     UPC_NOTFOUND};
            UPC_SRCH:       w = '{ACT_SRCH,      COND_MORE_SCAN, UPC_SRCH};
            UPC_SRCH_END:   w = '{ACT_SRCH_END,  COND_PEND,      UPC_DONE};
            UPC_NOTFOUND:   w = '{ACT_NOTFOUND,  COND_ALWAYS,    UPC_IDLE};
            default:        w = '{ACT_NONE,      COND_ALWAYS,    UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/bsls_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> hdl/bubble_sort_and_linear_search.sv
// Top level of the sort/search block: control-store sequencer, datapath and entry RAM.
//
// Items are taken when start is high and busy is low. A load (op 0) stores its
// value in the next free entry; loads beyond MAX_ENTRIES are dropped silently,
// and the first load after a closed list starts a new list. A load with last
// set sorts the loaded entries ascending (signed) and then emits every entry in
// order as kind SORTED with its 1-based position, the final one flagged by
// last_res. A search (op 1) scans all loaded entries and emits one MATCH per
// equal entry, or a single NONE result with position 0. Results leave through
// an output register, one per cycle at most, each valid for exactly one cycle
// with o_valid; the receiver cannot stall them, so it must take every strobe.
// The bubble sort walks the one-write, one-read entry RAM one compare-swap per
// cycle, and a search reads one entry per cycle. Each result shows in the cycle
// after the step that makes it, so the last one may appear in the first cycle
// that busy is low.
module bubble_sort_and_linear_search #(
    parameter int MAX_ENTRIES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  bsls_pkg::t_in_item  i_item,
    output logic                o_valid,
    output bsls_pkg::t_out_item o_res
);
    import bsls_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    // sequencer
    t_upc   r_upc, n_upc;
    t_uword w_uw;
    logic   w_take;

    // control state
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_closed, n_closed;
    logic          r_pend, n_pend;
    logic          r_valid, n_valid;

    // datapath registers
    t_in_item                 r_item;
    logic [CW-1:0]            r_j, n_j;
    logic [CW-1:0]            r_lim, n_lim;     // last index of the current pass
    logic signed [DATA_W-1:0] r_cur, n_cur;     // value carried up the pass
    logic [POS_W-1:0]         r_ppos, n_ppos;   // held match, sent once the next is known
    t_out_item                r_res, n_res;

    // RAM port
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [DATA_W-1:0] w_wdata, w_rdata;

    logic [CW-1:0] w_j1, w_j2, w_base;
    logic          w_room, w_accept;

    assign w_accept = start && !busy;
    assign busy     = (r_upc != UPC_IDLE);
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    assign w_j1   = r_j + CW'(1);
    assign w_j2   = r_j + CW'(2);
    assign w_base = r_closed ? '0 : r_cnt;
    assign w_room = (w_base < MAX_CNT);

    bsls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // --- next micro-address: jump on condition, else step ---
    always_comb begin
        w_uw = uc_rom(r_upc);
        unique case (w_uw.cond)
            COND_NEVER:     w_take = 1'b0;
            COND_ALWAYS:    w_take = 1'b1;
            COND_NOT_START: w_take = !start;
            COND_IS_SEARCH: w_take = (r_item.op == OP_SEARCH);
            COND_NOT_LAST:  w_take = !r_item.last;
            COND_FEW:       w_take = (r_cnt < CW'(2));
            COND_MORE_STEP: w_take = (w_j1 < r_lim);
            COND_MORE_PASS: w_take = (r_lim > CW'(1));
            COND_MORE_SCAN: w_take = (w_j1 < r_cnt);
            COND_EMPTY:     w_take = (r_cnt == '0);
            COND_PEND:      w_take = r_pend;
            default:        w_take = 1'b1;
        endcase
        n_upc = w_take ? w_uw.target : r_upc + t_upc'(1);
    end

    // --- datapath driven by the current control word ---
    always_comb begin
        n_cnt    = r_cnt;
        n_closed = r_closed;
        n_pend   = r_pend;
        n_j      = r_j;
        n_lim    = r_lim;
        n_cur    = r_cur;
        n_ppos   = r_ppos;
        n_valid  = 1'b0;
        n_res    = r_res;
        w_we     = 1'b0;
        w_waddr  = r_j[AW-1:0];
        w_wdata  = r_cur;
        w_raddr  = w_j1[AW-1:0];

        case (w_uw.act)
            ACT_LOAD: begin
                // a closed list restarts; a full store drops the value
                w_we     = w_room;
                w_waddr  = w_base[AW-1:0];
                w_wdata  = r_item.value;
                n_cnt    = w_base + CW'(w_room);
                n_closed = r_item.last;
            end
            ACT_SORT_INIT: begin
                n_lim = r_cnt - CW'(1);
            end
            ACT_RD_FIRST: begin
                w_raddr = '0;
                n_j     = '0;
                n_pend  = 1'b0;
            end
            ACT_TAKE_CUR: begin
                n_cur = w_rdata;
            end
            ACT_STEP: begin
                // keep the larger value moving; drop the smaller at index j
                w_we    = 1'b1;
                w_raddr = w_j2[AW-1:0];
                n_j     = w_j1;
                if (r_cur > $signed(w_rdata)) begin
                    w_wdata = w_rdata;
                end else begin
                    w_wdata = r_cur;
                    n_cur   = w_rdata;
                end
            end
            ACT_PASS_END: begin
                w_we    = 1'b1;
                w_waddr = r_lim[AW-1:0];
                n_lim   = r_lim - CW'(1);
            end
            ACT_EMIT: begin
                n_j     = w_j1;
                n_valid = 1'b1;
                n_res   = '{kind: KIND_SORTED, value_res: w_rdata,
                            position: POS_W'(w_j1), last_res: (w_j1 == r_cnt)};
            end
            ACT_SRCH: begin
                n_j = w_j1;
                if (w_rdata == r_item.value) begin
                    n_pend  = 1'b1;
                    n_ppos  = POS_W'(w_j1);
                    n_valid = r_pend;
                    n_res   = '{kind: KIND_MATCH, value_res: r_item.value,
                                position: r_ppos, last_res: 1'b0};
                end
            end
            ACT_SRCH_END: begin
                n_valid = r_pend;
                n_res   = '{kind: KIND_MATCH, value_res: r_item.value,
                            position: r_ppos, last_res: 1'b1};
            end
            ACT_NOTFOUND: begin
                n_valid = 1'b1;
                n_res   = '{kind: KIND_NONE, value_res: r_item.value,
                            position: '0, last_res: 1'b1};
            end
            default: begin
            end
        endcase
    end

    // --- registers ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc    <= UPC_IDLE;
            r_cnt    <= '0;
            r_closed <= 1'b0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_upc    <= n_upc;
            r_cnt    <= n_cnt;
            r_closed <= n_closed;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        r_j    <= n_j;
        r_lim  <= n_lim;
        r_cur  <= n_cur;
        r_ppos <= n_ppos;
        r_res  <= n_res;
    end
endmodule

>>> hdl/bsls_checker.sv
// Port-level checker for the sort/search block, bound to its top level.
module bsls_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input bsls_pkg::t_in_item  i_item,
    input logic                o_valid,
    input bsls_pkg::t_out_item o_res
);
    import bsls_pkg::*;

    // reset leaves the block ready for an item
    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !busy)
        else $error("busy high right after reset");

    // an accepted item always occupies the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but busy stayed low");

    // results only come from work in flight
    a_valid_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // not-found is always a lone, final result at position 0
    a_none_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.kind == KIND_NONE) |-> (o_res.position == '0 && o_res.last_res))
        else $error("malformed not-found result");

    // sorted values and matches carry a 1-based position
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.kind == KIND_SORTED || o_res.kind == KIND_MATCH))
            |-> (o_res.position != '0))
        else $error("zero position on a sorted or match result");
endmodule

bind bubble_sort_and_linear_search bsls_checker u_bsls_checker (.*);
